@@ hw/rtl/cti_pkg.sv @@
// Shared types and constants for the coverage threshold interval finder.
`timescale 1ns / 1ps

package cti_pkg;

  localparam int unsigned PosW          = 31;
  localparam int unsigned WinLenW       = 8;
  localparam int unsigned CountW        = 16;
  localparam int unsigned WindowSizeDef = 128;
  localparam int unsigned MaxResults    = 64;
  localparam int unsigned ApbDataW      = 32;
  localparam int unsigned ApbAddrW      = 4;
  localparam int unsigned TDataW        = 64;

  localparam logic [PosW-1:0]   PosMax   = {PosW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    RegWindowStart  = 2'd0,
    RegWindowLength = 2'd1,
    RegMinCoverage  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [PosW-1:0]    window_start;
    logic [WinLenW-1:0] window_length;
    logic [CountW-1:0]  min_coverage;
  } cfg_t;

  localparam logic [PosW-1:0]    WindowStartRst  = '0;
  localparam logic [WinLenW-1:0] WindowLengthRst = 8'd128;
  localparam logic [CountW-1:0]  MinCoverageRst  = 16'd1;

endpackage

@@ hw/rtl/coverage_threshold_intervals.sv @@
// Top level: read coverage counter with threshold run extraction.
`timescale 1ns / 1ps
//
// Usage:
//  - Input stream (s_axis_*): one request per item. tuser = cmd (0 add, 1 finish),
//    tdata = {zeros, read_end, read_start}. Taken only while the block is idle.
//  - Output stream (m_axis_*): one request per covered run found by a finish.
//    tdata = {zeros, interval_end, interval_start}, tuser = none_found, tlast
//    marks the final result of a finish. At most 64 results per finish.
//  - APB port: window_start @0x0, window_length @0x4, min_coverage @0x8.
//    Write only while idle.
// Timing:
//  - Add: one position per cycle, the count memory reading one position ahead
//    while writing the previous one back through its separate write port.
//  - Finish: the scan reads (S_RD) and clears (S_EV) each count in turn, so
//    the whole store is zeroed; it also waits on output stalls.
// A stalled receiver holds the output register; the scan waits only when a
// new run must displace a held result and the output register is still full.
// Reset restores register defaults and zeroes the store at once through
// per-entry valid bits; no clearing pass is needed.

module coverage_threshold_intervals
  import cti_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = WindowSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TDataW-1:0]   s_axis_tdata,   // [30:0] read_start, [61:31] read_end
  input  logic                s_axis_tuser,   // [0] cmd
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TDataW-1:0]   m_axis_tdata,   // [30:0] interval_start, [61:31] interval_end
  output logic                m_axis_tuser,   // [0] none_found
  output logic                m_axis_tlast,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int unsigned KW   = $clog2(WINDOW_SIZE);
  localparam int unsigned LW   = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned CntW = $clog2(MaxResults + 1);
  localparam logic [LW-1:0]   WinSizeL = LW'(WINDOW_SIZE);
  localparam logic [KW-1:0]   KLast    = KW'(WINDOW_SIZE - 1);
  localparam logic [CntW-1:0] CntMax   = CntW'(MaxResults);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADD  = 6'b000010,
    S_RD   = 6'b000100,
    S_EV   = 6'b001000,
    S_FIN  = 6'b010000,
    S_LAST = 6'b100000
  } state_e;

  cfg_t cfg;

  cti_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // ---------------------------------------------------------------------------
  // Effective window: capped by store depth and by the top of position space
  // ---------------------------------------------------------------------------
  logic [PosW-1:0] room, wend;
  logic [LW-1:0]   cap_len, eff_len;

  always_comb begin
    room    = PosMax - cfg.window_start;
    cap_len = (cfg.window_length > 8'(WINDOW_SIZE)) ? WinSizeL : LW'(cfg.window_length);
    eff_len = (room < PosW'(cap_len)) ? LW'(room) : cap_len;
    wend    = cfg.window_start + PosW'(eff_len);
  end

  // ---------------------------------------------------------------------------
  // Count memory with registered read data; valid bits give the zero reset
  // ---------------------------------------------------------------------------
  logic [CountW-1:0]      mem_q [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] vld_q;
  logic [CountW-1:0]      rdata_q;
  logic                   rvld_q;
  logic                   mem_re, mem_we;
  logic [KW-1:0]          mem_raddr, mem_waddr;
  logic [CountW-1:0]      mem_wdata, rd_cnt;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (mem_we) vld_q[mem_waddr] <= 1'b1;
      if (mem_re) rvld_q <= vld_q[mem_raddr];
    end
  end

  assign rd_cnt = rvld_q ? rdata_q : '0;

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  state_e          state_q, state_d;
  logic [LW-1:0]   ka_q, ka_d, ke_q, ke_d;   // add sweep: next read, end (exclusive)
  logic            pv_q, pv_d;               // add: a read is in flight
  logic [KW-1:0]   pa_q, pa_d;               // add: its address
  logic [KW-1:0]   k_q, k_d;                 // scan position
  logic            in_run_q, in_run_d;
  logic [PosW-1:0] run_s_q, run_s_d;
  logic            pend_v_q, pend_v_d;       // held result, sent once the next is known
  logic [PosW-1:0] pend_s_q, pend_s_d, pend_e_q, pend_e_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic            out_v_q;
  logic [PosW-1:0] out_s_q, out_e_q;
  logic            out_none_q, out_last_q;
  logic            out_load, out_free;
  logic [PosW-1:0] ld_s, ld_e;
  logic            ld_none, ld_last;

  logic            in_acc;
  logic [PosW-1:0] rs, re, lo, hi, pos;
  logic            cov, close_run, new_res, stall;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign rs            = s_axis_tdata[PosW-1:0];
  assign re            = s_axis_tdata[2*PosW-1:PosW];
  assign out_free      = !out_v_q || m_axis_tready;
  assign pos           = cfg.window_start + PosW'(k_q);

  always_comb begin
    state_d  = state_q;
    ka_d     = ka_q;
    ke_d     = ke_q;
    pv_d     = pv_q;
    pa_d     = pa_q;
    k_d      = k_q;
    in_run_d = in_run_q;
    run_s_d  = run_s_q;
    pend_v_d = pend_v_q;
    pend_s_d = pend_s_q;
    pend_e_d = pend_e_q;
    cnt_d    = cnt_q;

    mem_re    = 1'b0;
    mem_raddr = k_q;
    mem_we    = 1'b0;
    mem_waddr = k_q;
    mem_wdata = '0;

    out_load = 1'b0;
    ld_s     = pend_s_q;
    ld_e     = pend_e_q;
    ld_none  = 1'b0;
    ld_last  = 1'b0;

    lo        = (rs > cfg.window_start) ? rs : cfg.window_start;
    hi        = (re < wend) ? re : wend;
    cov       = (LW'(k_q) < eff_len) && (rd_cnt >= cfg.min_coverage);
    close_run = 1'b0;
    new_res   = 1'b0;
    stall     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            k_d      = '0;
            in_run_d = 1'b0;
            pend_v_d = 1'b0;
            cnt_d    = '0;
            state_d  = S_RD;
          end else begin
            if (lo < hi) begin
              ka_d = LW'(lo - cfg.window_start);
              ke_d = LW'(hi - cfg.window_start);
            end else begin
              ka_d = '0;
              ke_d = '0;
            end
            pv_d    = 1'b0;
            state_d = S_ADD;
          end
        end
      end

      S_ADD: begin
        // read one position ahead, write back the previous one (distinct entries)
        if (pv_q) begin
          mem_we    = 1'b1;
          mem_waddr = pa_q;
          mem_wdata = (rd_cnt == CountMax) ? rd_cnt : rd_cnt + 1'b1;
        end
        if (ka_q < ke_q) begin
          mem_re    = 1'b1;
          mem_raddr = ka_q[KW-1:0];
          pa_d      = ka_q[KW-1:0];
          pv_d      = 1'b1;
          ka_d      = ka_q + 1'b1;
        end else begin
          pv_d = 1'b0;
          if (!pv_q) state_d = S_IDLE;
        end
      end

      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_EV;
      end

      S_EV: begin
        close_run = in_run_q && !cov;
        new_res   = close_run && (cnt_q < CntMax);
        stall     = new_res && pend_v_q && !out_free;
        if (!stall) begin
          mem_we = 1'b1;   // clear as we go
          if (new_res) begin
            out_load = pend_v_q;
            pend_v_d = 1'b1;
            pend_s_d = run_s_q;
            pend_e_d = pos;
            cnt_d    = cnt_q + 1'b1;
          end
          if (cov && !in_run_q) begin
            in_run_d = 1'b1;
            run_s_d  = pos;
          end else if (close_run) begin
            in_run_d = 1'b0;
          end
          if (k_q == KLast) begin
            state_d = S_FIN;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_RD;
          end
        end
      end

      S_FIN: begin
        // a run still open at the end closes at the window end
        new_res = in_run_q && (cnt_q < CntMax);
        stall   = new_res && pend_v_q && !out_free;
        if (!stall) begin
          if (new_res) begin
            out_load = pend_v_q;
            pend_v_d = 1'b1;
            pend_s_d = run_s_q;
            pend_e_d = wend;
          end
          in_run_d = 1'b0;
          state_d  = S_LAST;
        end
      end

      S_LAST: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_last  = 1'b1;
          if (!pend_v_q) begin
            ld_s    = '0;
            ld_e    = '0;
            ld_none = 1'b1;
          end
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pv_q     <= 1'b0;
      in_run_q <= 1'b0;
      pend_v_q <= 1'b0;
      cnt_q    <= '0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pv_q     <= pv_d;
      in_run_q <= in_run_d;
      pend_v_q <= pend_v_d;
      cnt_q    <= cnt_d;
      if (out_load)           out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ka_q     <= ka_d;
    ke_q     <= ke_d;
    pa_q     <= pa_d;
    k_q      <= k_d;
    run_s_q  <= run_s_d;
    pend_s_q <= pend_s_d;
    pend_e_q <= pend_e_d;
    if (out_load) begin
      out_s_q    <= ld_s;
      out_e_q    <= ld_e;
      out_none_q <= ld_none;
      out_last_q <= ld_last;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(TDataW - 2*PosW){1'b0}}, out_e_q, out_s_q};
  assign m_axis_tuser  = out_none_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ hw/rtl/cti_apb_regs.sv @@
// APB register file holding the window and threshold settings.
`timescale 1ns / 1ps

module cti_apb_regs
  import cti_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        RegWindowStart:  cfg_d.window_start  = pwdata[PosW-1:0];
        RegWindowLength: cfg_d.window_length = pwdata[WinLenW-1:0];
        RegMinCoverage:  cfg_d.min_coverage  = pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      RegWindowStart:  prdata = ApbDataW'(cfg_q.window_start);
      RegWindowLength: prdata = ApbDataW'(cfg_q.window_length);
      RegMinCoverage:  prdata = ApbDataW'(cfg_q.min_coverage);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_start  <= WindowStartRst;
      cfg_q.window_length <= WindowLengthRst;
      cfg_q.min_coverage  <= MinCoverageRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the coverage threshold interval finder.
`timescale 1ns / 1ps

module tb_top;
  import cti_pkg::*;

  // Store depth used for the DUT and the predictor alike.
  localparam int unsigned Depth      = WindowSizeDef;
  // Longest internal activity with no result in sight: a full finish scan
  // (or a full-window add) plus margin.
  localparam int unsigned SettleCyc  = 2 * Depth + 10;
  // Watchdog. Even with every request a 64-result finish behind a slow
  // receiver, a run stays far below this limit.
  localparam int unsigned CycleLimit = 2_000_000;
  // Total requests over the whole run, directed part included.
  localparam int unsigned RandItems  = 130;
  localparam int unsigned LongHold   = 500;

  // Request kinds carried on s_axis_tuser.
  localparam logic CmdAdd    = 1'b0;
  localparam logic CmdFinish = 1'b1;

  // One covered-run result as seen on the output stream.
  typedef struct packed {
    logic [PosW-1:0] run_first;
    logic [PosW-1:0] run_past;
    logic            none_found;
    logic            last;
  } cov_run_t;

  // Depth predictor plus queue of runs still owed by the DUT.
  class run_scoreboard;
    logic [CountW-1:0] read_depth [Depth];
    cfg_t              cfg;
    cov_run_t          expected_runs [$];
    int unsigned       mismatches;

    function new();
      foreach (read_depth[k]) read_depth[k] = '0;
      cfg.window_start  = WindowStartRst;
      cfg.window_length = WindowLengthRst;
      cfg.min_coverage  = MinCoverageRst;
      mismatches = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [ApbDataW-1:0] value);
      case (idx)
        RegWindowStart:  cfg.window_start  = value[PosW-1:0];
        RegWindowLength: cfg.window_length = value[WinLenW-1:0];
        RegMinCoverage:  cfg.min_coverage  = value[CountW-1:0];
        default: ;
      endcase
    endfunction

    // Append one run to the owed results.
    function void owe_run(cov_run_t run);
      expected_runs = {expected_runs, run};
    endfunction

    // Apply one accepted request: an add bumps depths, a finish queues runs.
    function void note_request(logic cmd, logic [PosW-1:0] rs, logic [PosW-1:0] re);
      logic [31:0] ws, len, room, wend, lo, hi, p, k, run_from;
      bit          in_run;
      int unsigned n;
      cov_run_t    found;
      ws   = 32'(cfg.window_start);
      len  = 32'(cfg.window_length);
      room = 32'(PosMax) - ws;
      if (len > Depth) len = Depth;
      if (len > room) len = room;
      wend = ws + len;
      if (cmd == CmdAdd) begin
        lo = (32'(rs) > ws) ? 32'(rs) : ws;
        hi = (32'(re) < wend) ? 32'(re) : wend;
        for (p = lo; p < hi; p++) begin
          k = p - ws;
          if (k < Depth && read_depth[k] != CountMax) read_depth[k]++;
        end
        return;
      end
      n        = 0;
      in_run   = 1'b0;
      run_from = '0;
      for (k = 0; k < len && k < Depth; k++) begin
        if (read_depth[k] >= cfg.min_coverage) begin
          if (!in_run) begin
            in_run   = 1'b1;
            run_from = ws + k;
          end
        end else if (in_run) begin
          in_run = 1'b0;
          if (n < MaxResults) begin
            p     = ws + k;
            found = cov_run_t'{run_from[PosW-1:0], p[PosW-1:0], 1'b0, 1'b0};
            owe_run(found);
            n++;
          end
        end
      end
      if (in_run && n < MaxResults) begin
        found = cov_run_t'{run_from[PosW-1:0], wend[PosW-1:0], 1'b0, 1'b0};
        owe_run(found);
        n++;
      end
      if (n == 0) begin
        found = cov_run_t'{'0, '0, 1'b1, 1'b1};
        owe_run(found);
      end else begin
        expected_runs[expected_runs.size()-1].last = 1'b1;
      end
      foreach (read_depth[i]) read_depth[i] = '0;
    endfunction

    // Print is capped to keep the log short; every mismatch is counted.
    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(cov_run_t got);
      cov_run_t want;
      if (expected_runs.size() == 0) begin
        report($sformatf("unexpected result [%0d,%0d) none=%0b last=%0b",
                         got.run_first, got.run_past, got.none_found, got.last));
        return;
      end
      want = expected_runs.pop_front();
      if (got.run_first !== want.run_first)
        report($sformatf("interval_start %0d, want %0d", got.run_first, want.run_first));
      if (got.run_past !== want.run_past)
        report($sformatf("interval_end %0d, want %0d", got.run_past, want.run_past));
      if (got.none_found !== want.none_found)
        report($sformatf("none_found %0b, want %0b", got.none_found, want.none_found));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // DUT connections; every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TDataW-1:0]   s_axis_tdata  = '0;    // [30:0] read_start, [61:31] read_end
  logic                s_axis_tuser  = 1'b0;  // [0] cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [TDataW-1:0]   m_axis_tdata;          // [30:0] interval_start, [61:31] interval_end
  logic                m_axis_tuser;          // [0] none_found
  logic                m_axis_tlast;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ApbAddrW-1:0] paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  run_scoreboard sb = new();

  // Sender burst state, receiver stall state, and run bookkeeping.
  int unsigned burst_left   = 0;
  int unsigned items_sent   = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned pattern_age  = 0;
  int unsigned cycle_count  = 0;
  logic [7:0]  ready_mask   = 8'hFF;
  logic [2:0]  mask_phase   = '0;

  coverage_threshold_intervals #(
    .WINDOW_SIZE(Depth)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** coverage_threshold_intervals: FAILED **");
      $finish;
    end
  end

  // Receiver: rotating 8-bit ready mask, re-rolled when pattern_age runs out (a
  // quarter of the time fully ready). A hold request forces tready low for as
  // long as it asks, counted here, so the DUT backs up into its input side.
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      if (pattern_age == 0) begin
        ready_mask  = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        pattern_age = 64;
      end
      pattern_age--;
      m_axis_tready <= ready_mask[mask_phase];
      mask_phase++;
    end
  end

  // Result monitor: sample at the rising edge, before any update of the edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(cov_run_t'{m_axis_tdata[PosW-1:0], m_axis_tdata[2*PosW-1:PosW],
                                 m_axis_tuser, m_axis_tlast});
  end

  // One request on the input stream. Sender runs in random bursts; tvalid
  // stays high across back-to-back requests (only data changes at negedge).
  task automatic send_request(logic cmd, logic [PosW-1:0] rs, logic [PosW-1:0] re);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, re, rs};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(cmd, rs, re);
    items_sent++;
  endtask

  // Stop offering, wait for every owed result, then let any trailing add or
  // store-clearing scan finish so the block is idle.
  task automatic quiesce();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_runs.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  // APB write (setup + access), then read back the same register.
  task automatic write_reg(reg_idx_e idx, logic [ApbDataW-1:0] value);
    logic [ApbDataW-1:0] want_rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      RegWindowStart:  want_rd = ApbDataW'(sb.cfg.window_start);
      RegWindowLength: want_rd = ApbDataW'(sb.cfg.window_length);
      default:         want_rd = ApbDataW'(sb.cfg.min_coverage);
    endcase
    if (prdata !== want_rd)
      sb.report($sformatf("readback of register %s: %0h, want %0h",
                          idx.name(), prdata, want_rd));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [ApbDataW-1:0] cfg_val;
    logic [31:0]         ws32, lo32;
    logic [PosW-1:0]     rs, re;
    int unsigned         set_idx;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // ---- Directed part ------------------------------------------------------
    // Empty store at reset settings: single none-found result.
    send_request(CmdFinish, '0, '0);
    // Overlapping reads, a read past the window end, empty and inverted reads,
    // a read covering the whole position range, and the top-position empty read.
    send_request(CmdAdd, 31'd5, 31'd10);
    send_request(CmdAdd, 31'd8, 31'd20);
    send_request(CmdAdd, 31'd0, PosMax);
    send_request(CmdAdd, 31'd100, 31'd200);
    send_request(CmdAdd, 31'd20, 31'd20);
    send_request(CmdAdd, 31'd30, 31'd25);
    send_request(CmdAdd, PosMax, PosMax);
    // Threshold changed after the adds: counts persist, finish uses new value.
    quiesce();
    write_reg(RegMinCoverage, 32'd2);
    send_request(CmdFinish, '0, '0);

    // Zero threshold: whole (cleared) window is one run.
    quiesce();
    write_reg(RegMinCoverage, 32'd0);
    send_request(CmdFinish, '0, '0);

    // Zero-length window: no run even though every position qualifies.
    quiesce();
    write_reg(RegWindowLength, 32'd0);
    send_request(CmdAdd, 31'd0, 31'd50);
    send_request(CmdFinish, '0, '0);

    // Highest legal window start with an oversized length (capped at the depth).
    quiesce();
    write_reg(RegWindowStart, 32'h7FFF_FF7F);
    write_reg(RegWindowLength, 32'd255);
    write_reg(RegMinCoverage, 32'd1);
    send_request(CmdAdd, 31'h7FFF_FF82, 31'h7FFF_FF84);
    send_request(CmdAdd, 31'h7FFF_FFF7, PosMax);
    send_request(CmdFinish, '0, '0);

    // Window start so high that the end is capped at the top position.
    quiesce();
    write_reg(RegWindowStart, 32'(PosMax - 31'd10));
    write_reg(RegWindowLength, 32'd128);
    send_request(CmdAdd, 31'd0, PosMax);
    send_request(CmdFinish, '0, '0);

    // Window moved between adds: counts stay with their store offset.
    quiesce();
    write_reg(RegWindowStart, 32'd1000);
    write_reg(RegWindowLength, 32'd16);
    send_request(CmdAdd, 31'd1000, 31'd1004);
    quiesce();
    write_reg(RegWindowStart, 32'd1002);
    send_request(CmdAdd, 31'd1002, 31'd1003);
    send_request(CmdFinish, '0, '0);

    // ---- Comb: every other position covered gives the full 64 results --------
    // The receiver then holds off for a long stretch while the sender keeps
    // offering the following random adds, so the input side stalls.
    quiesce();
    write_reg(RegWindowStart, 32'($urandom_range(0, 100000)));
    write_reg(RegWindowLength, 32'(Depth));
    write_reg(RegMinCoverage, 32'd1);
    for (int i = 0; i < Depth / 2; i++)
      send_request(CmdAdd, sb.cfg.window_start + 31'(2 * i),
                   sb.cfg.window_start + 31'(2 * i + 1));
    hold_request = LongHold;
    send_request(CmdFinish, '0, '0);

    // ---- Random part: sets of adds closed by a finish -----------------------
    // Every third set reprograms the window after draining all results.
    set_idx    = 0;
    while (items_sent < RandItems) begin
      if (set_idx % 3 == 2) begin
        quiesce();
        case ($urandom_range(0, 5))
          0:       cfg_val = 32'd0;
          1:       cfg_val = 32'h7FFF_FF7F;
          2:       cfg_val = 32'(PosMax) - $urandom_range(0, 127);
          3:       cfg_val = {1'b0, 31'($urandom)};
          default: cfg_val = $urandom_range(0, 5000);
        endcase
        write_reg(RegWindowStart, cfg_val);
        case ($urandom_range(0, 5))
          0:       cfg_val = 32'd0;
          1:       cfg_val = $urandom_range(129, 255);
          2:       cfg_val = 32'(Depth);
          default: cfg_val = $urandom_range(1, 128);
        endcase
        write_reg(RegWindowLength, cfg_val);
        case ($urandom_range(0, 7))
          0:       cfg_val = 32'd0;
          1:       cfg_val = 32'(CountMax);
          2:       cfg_val = $urandom_range(4, 65535);
          default: cfg_val = $urandom_range(1, 3);
        endcase
        write_reg(RegMinCoverage, cfg_val);
      end
      repeat ($urandom_range(0, 10)) begin
        ws32 = 32'(sb.cfg.window_start);
        case ($urandom_range(0, 9))
          0: begin
            // anywhere in the position range, mostly outside the window
            rs = 31'($urandom);
            re = 31'($urandom);
          end
          1: begin
            // empty or inverted
            rs = sb.cfg.window_start + 31'($urandom_range(0, 160));
            re = rs - 31'($urandom_range(0, 5));
          end
          default: begin
            // near or across the window edges
            lo32 = ws32 + $urandom_range(0, 160) - 16;
            rs   = lo32[PosW-1:0];
            re   = rs + 31'($urandom_range(1, 48));
          end
        endcase
        send_request(CmdAdd, rs, re);
      end
      // Data fields of a finish are don't-care; randomize them anyway.
      send_request(CmdFinish, 31'($urandom), 31'($urandom));
      set_idx++;
    end

    quiesce();
    if (sb.mismatches == 0 && sb.expected_runs.size() == 0) begin
      $display("** coverage_threshold_intervals: PASSED **");
    end else begin
      $display("** coverage_threshold_intervals: FAILED **");
    end
    $finish;
  end

endmodule
